@@ hdl/iaf_pkg.sv @@
// ----------------------------------------------------------------------------
// Integer-to-ASCII formatter package
// Shared type, constants and a helper function.
// ----------------------------------------------------------------------------
package iaf_pkg;

  localparam int MaxChars = 64;
  localparam int InWidth  = 96;
  localparam int OutWidth = 8;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChCapX  = 8'h58;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChCapA  = 8'h41;

  typedef struct packed {
    logic [63:0]       mag;
    logic [5:0]        radix;
    logic [5:0]        fw;
    logic signed [6:0] prec;
    logic              upper;
    logic              left;
    logic              has_sign;
    logic [7:0]        sign_char;
    logic              zero_fill;
    logic [1:0]        pfx;
    logic              bad;
  } iaf_desc_t;

  function automatic logic [7:0] digit_char(logic [5:0] r, logic upper);
    logic [7:0] r8;
    r8 = {2'b00, r};
    if (r < 6'd10) begin
      return ChZero + r8;
    end
    return (upper ? ChCapA : ChLowA) + r8 - 8'd10;
  endfunction

endpackage

@@ hdl/integer_to_ascii_formatter_core.sv @@
// ----------------------------------------------------------------------------
// Integer-to-ASCII formatter core
// Converts one integer with printf-style settings into a stream of characters.
// ----------------------------------------------------------------------------
// Each accepted item produces up to 64 character beats, or one error beat for
// an invalid radix. An item leaves the queue; the radix divider, which
// retires 8 quotient bits a cycle, then writes each digit into the digit
// store; a setup step sizes the field; and the fields are emitted one
// character per beat, each digit waiting on its digit store read. A beat
// that waits for the receiver stalls the emission. A two-entry queue lets
// new items be accepted while the back end works.
module integer_to_ascii_formatter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // number, radix, min_width, min_digits, operand_size, is_signed,
  // upper_case, pad_right, force_plus, blank_sign, alt_prefix, zero_pad
  input  logic [iaf_pkg::InWidth-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_char
  output logic [iaf_pkg::OutWidth-1:0] m_axis_tdata,
  output logic                        m_axis_tlast,
  // bad_radix, truncated
  output logic [1:0]                  m_axis_tuser
);
  import iaf_pkg::*;

  iaf_desc_t front_desc, queue_desc;
  logic      full, empty, pop, push;

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;

  iaf_front u_front (
    .tdata_i (s_axis_tdata),
    .desc_o  (front_desc)
  );

  iaf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_desc),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (queue_desc)
  );

  iaf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .desc_i     (queue_desc),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_char_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast),
    .m_bad_o    (m_axis_tuser[0]),
    .m_trunc_o  (m_axis_tuser[1])
  );

endmodule

@@ hdl/iaf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/iaf_front.sv @@
// ----------------------------------------------------------------------------
// Formatter front end
// Masks the operand, resolves sign, fill and prefix, and checks the radix.
// ----------------------------------------------------------------------------
module iaf_front (
  input  logic [iaf_pkg::InWidth-1:0] tdata_i,
  output iaf_pkg::iaf_desc_t          desc_o
);
  import iaf_pkg::*;

  logic [63:0] num;
  logic [5:0]  radix;
  logic [1:0]  size;
  logic        sgn, plus, space, alt, zpad, left;
  logic [63:0] mask, x;
  logic        neg;

  assign num   = tdata_i[63:0];
  assign radix = tdata_i[69:64];
  assign size  = tdata_i[84:83];
  assign sgn   = tdata_i[85];
  assign left  = tdata_i[87];
  assign plus  = tdata_i[88];
  assign space = tdata_i[89];
  assign alt   = tdata_i[90];
  assign zpad  = tdata_i[91];

  always_comb begin
    unique case (size)
      2'd0:    mask = 64'h0000_0000_0000_00ff;
      2'd1:    mask = 64'h0000_0000_0000_ffff;
      2'd2:    mask = 64'h0000_0000_ffff_ffff;
      default: mask = '1;
    endcase
    x = num & mask;
    unique case (size)
      2'd0:    neg = sgn & x[7];
      2'd1:    neg = sgn & x[15];
      2'd2:    neg = sgn & x[31];
      default: neg = sgn & x[63];
    endcase

    desc_o.radix     = radix;
    desc_o.fw        = tdata_i[75:70];
    desc_o.prec      = tdata_i[82:76];
    desc_o.upper     = tdata_i[86];
    desc_o.left      = left;
    desc_o.zero_fill = zpad & ~left;
    desc_o.bad       = (radix < 6'd2) || (radix > 6'd36);
    desc_o.pfx       = (x != 64'd0 && alt) ? ((radix == 6'd16) ? 2'd2 : 2'd1) : 2'd0;
    if (neg) begin
      desc_o.mag       = (64'd0 - x) & mask;
      desc_o.has_sign  = 1'b1;
      desc_o.sign_char = ChMinus;
    end else begin
      desc_o.mag       = x;
      desc_o.has_sign  = (sgn || size == 2'd3) && (plus || space);
      desc_o.sign_char = plus ? ChPlus : ChSpace;
    end
  end

endmodule

@@ hdl/iaf_queue.sv @@
// ----------------------------------------------------------------------------
// Descriptor queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module iaf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  iaf_pkg::iaf_desc_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output iaf_pkg::iaf_desc_t rdata_o
);
  import iaf_pkg::*;

  iaf_desc_t  entry_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign rdata_o = entry_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q ^ push_i;
    rptr_d  = rptr_q ^ pop_i;
    count_d = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ hdl/iaf_back.sv @@
// ----------------------------------------------------------------------------
// Formatter back end
// Divides out the digits into the digit store and emits the characters, or an error beat for a bad radix.
// ----------------------------------------------------------------------------
module iaf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  iaf_pkg::iaf_desc_t desc_i,
  output logic               pop_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [7:0]         m_char_o,
  output logic               m_last_o,
  output logic               m_bad_o,
  output logic               m_trunc_o
);
  import iaf_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDiv   = 3'd1;
  localparam logic [2:0] StSetup = 3'd2;
  localparam logic [2:0] StEmit  = 3'd3;
  localparam logic [2:0] StErr   = 3'd4;

  localparam logic [2:0] PhPadL = 3'd0;
  localparam logic [2:0] PhSign = 3'd1;
  localparam logic [2:0] PhPfx  = 3'd2;
  localparam logic [2:0] PhZero = 3'd3;
  localparam logic [2:0] PhDig  = 3'd4;
  localparam logic [2:0] PhPadR = 3'd5;
  localparam logic [2:0] PhEnd  = 3'd6;

  logic [2:0]  state_q, state_d;
  iaf_desc_t   desc_q, desc_d;
  logic [63:0] quo_q, quo_d;
  logic [5:0]  rem_q, rem_d;
  logic [2:0]  bit_q, bit_d;
  logic [6:0]  nd_q, nd_d;
  logic [5:0]  zeros_q, zeros_d, padw_q, padw_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        trunc_q, trunc_d;
  logic [2:0]  p_q, p_d;
  logic [6:0]  pos_q, pos_d, k_q, k_d;
  logic        rd_ok_q, rd_ok_d;
  logic        ov_q, ov_d, oc_last_q, oc_last_d, ob_q, ob_d, ot_q, ot_d;
  logic [7:0]  oc_q, oc_d;

  logic [63:0] dq;
  logic [6:0]  dr;
  logic        we;
  logic [7:0]  wdata, rdata;
  logic [5:0]  raddr;
  logic        out_free;
  logic [2:0]  phase;
  logic [6:0]  plen;
  logic [7:0]  pch;
  logic [7:0]  n_all, n_dig, fw8, w8, sp8, len8;
  logic [6:0]  prec_pos;

  assign out_free = !ov_q || m_tready_i;
  assign raddr    = 6'(nd_q - 7'd1 - pos_q);
  assign wdata    = digit_char(dr[5:0], desc_q.upper);
  assign pop_o    = (state_q == StIdle) && !empty_i;

  iaf_ram #(.WIDTH(8), .DEPTH(MaxChars)) u_digits (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (nd_q[5:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    dq = quo_q;
    dr = {1'b0, rem_q};
    for (int i = 0; i < 8; i++) begin
      dr = {dr[5:0], dq[63]};
      dq = {dq[62:0], 1'b0};
      if (dr >= {1'b0, desc_q.radix}) begin
        dr    = dr - {1'b0, desc_q.radix};
        dq[0] = 1'b1;
      end
    end
  end

  always_comb begin
    if (p_q == PhEnd) begin
      phase = PhEnd;
    end else if (desc_q.zero_fill) begin
      unique case (p_q)
        3'd0:    phase = PhPfx;
        3'd1:    phase = PhSign;
        3'd2:    phase = PhPadL;
        3'd3:    phase = PhZero;
        3'd4:    phase = PhDig;
        default: phase = PhPadR;
      endcase
    end else begin
      unique case (p_q)
        3'd0:    phase = PhPadL;
        3'd1:    phase = PhSign;
        3'd2:    phase = PhPfx;
        3'd3:    phase = PhZero;
        3'd4:    phase = PhDig;
        default: phase = PhPadR;
      endcase
    end
    unique case (phase)
      PhPadL:  plen = desc_q.left ? 7'd0 : {1'b0, padw_q};
      PhSign:  plen = {6'd0, desc_q.has_sign};
      PhPfx:   plen = {5'd0, desc_q.pfx};
      PhZero:  plen = {1'b0, zeros_q};
      PhDig:   plen = nd_q;
      PhPadR:  plen = desc_q.left ? {1'b0, padw_q} : 7'd0;
      default: plen = 7'd0;
    endcase
    unique case (phase)
      PhPadL:  pch = desc_q.zero_fill ? ChZero : ChSpace;
      PhSign:  pch = desc_q.sign_char;
      PhPfx:   pch = (pos_q == 7'd0) ? ChZero : (desc_q.upper ? ChCapX : ChLowX);
      PhZero:  pch = ChZero;
      PhDig:   pch = rdata;
      default: pch = ChSpace;
    endcase
  end

  always_comb begin
    prec_pos = desc_q.prec[6] ? 7'd0 : 7'(desc_q.prec);
    zeros_d  = zeros_q;
    if (state_q == StSetup) begin
      zeros_d = (prec_pos > nd_q) ? 6'(prec_pos - nd_q) : 6'd0;
    end
    n_dig = {1'b0, nd_q} + {2'b00, zeros_d};
    sp8   = {7'd0, desc_q.has_sign} + {6'd0, desc_q.pfx};
    n_all = n_dig + sp8;
    fw8   = {2'b00, desc_q.fw};
    if (desc_q.zero_fill) begin
      w8 = (fw8 > n_dig) ? fw8 - n_dig : 8'd0;
      w8 = (w8 > sp8) ? w8 - sp8 : 8'd0;
    end else begin
      w8 = (fw8 > n_all) ? fw8 - n_all : 8'd0;
    end
    len8 = w8 + n_all;
  end

  always_comb begin
    state_d   = state_q;
    desc_d    = desc_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    bit_d     = bit_q;
    nd_d      = nd_q;
    padw_d    = padw_q;
    cnt_d     = cnt_q;
    trunc_d   = trunc_q;
    p_d       = p_q;
    pos_d     = pos_q;
    k_d       = k_q;
    rd_ok_d   = 1'b1;
    we        = 1'b0;
    ov_d      = ov_q && !m_tready_i;
    oc_d      = oc_q;
    oc_last_d = oc_last_q;
    ob_d      = ob_q;
    ot_d      = ot_q;
    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          desc_d = desc_i;
          quo_d  = desc_i.mag;
          rem_d  = 6'd0;
          bit_d  = 3'd0;
          nd_d   = 7'd0;
          if (desc_i.bad) begin
            state_d = StErr;
          end else if (desc_i.mag == 64'd0 && desc_i.prec == 7'sd0) begin
            state_d = StSetup;
          end else begin
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        quo_d = dq;
        rem_d = dr[5:0];
        bit_d = bit_q + 3'd1;
        if (bit_q == 3'd7) begin
          we    = 1'b1;
          nd_d  = nd_q + 7'd1;
          rem_d = 6'd0;
          if (dq == 64'd0 || nd_q == 7'(MaxChars - 1)) begin
            state_d = StSetup;
          end
        end
      end
      StSetup: begin
        padw_d  = w8[5:0];
        trunc_d = len8 > 8'(MaxChars);
        cnt_d   = (len8 > 8'(MaxChars)) ? 7'(MaxChars) : len8[6:0];
        p_d     = 3'd0;
        pos_d   = 7'd0;
        k_d     = 7'd0;
        state_d = StEmit;
      end
      StEmit: begin
        if (phase == PhEnd) begin
          state_d = StIdle;
        end else if (pos_q >= plen) begin
          p_d     = p_q + 3'd1;
          pos_d   = 7'd0;
          rd_ok_d = 1'b0;
        end else if ((phase != PhDig || rd_ok_q) && out_free) begin
          ov_d      = 1'b1;
          oc_d      = pch;
          ob_d      = 1'b0;
          oc_last_d = (k_q + 7'd1) == cnt_q;
          ot_d      = ((k_q + 7'd1) == cnt_q) && trunc_q;
          pos_d     = pos_q + 7'd1;
          k_d       = k_q + 7'd1;
          rd_ok_d   = 1'b0;
          if ((k_q + 7'd1) == cnt_q) begin
            state_d = StIdle;
          end
        end
      end
      StErr: begin
        if (out_free) begin
          ov_d      = 1'b1;
          oc_d      = 8'd0;
          oc_last_d = 1'b1;
          ob_d      = 1'b1;
          ot_d      = 1'b0;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
      k_q     <= 7'd0;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      k_q     <= k_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q    <= desc_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    bit_q     <= bit_d;
    nd_q      <= nd_d;
    zeros_q   <= zeros_d;
    padw_q    <= padw_d;
    cnt_q     <= cnt_d;
    trunc_q   <= trunc_d;
    p_q       <= p_d;
    pos_q     <= pos_d;
    oc_q      <= oc_d;
    oc_last_q <= oc_last_d;
    ob_q      <= ob_d;
    ot_q      <= ot_d;
  end

  assign m_tvalid_o = ov_q;
  assign m_char_o   = oc_q;
  assign m_last_o   = oc_last_q;
  assign m_bad_o    = ob_q;
  assign m_trunc_o  = ot_q;

endmodule
